### sv/assert_macros.svh
// Assertion helper macros for the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that is disabled while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Check that holds during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### sv/wfba_pkg.sv
// Shared types and constants of the worst-fit block allocator.
// No dependencies.
package wfba_pkg;

  // Fixed field widths
  localparam int ActW  = 5;
  localparam int BlkW  = 4;

  localparam logic [ActW-1:0] ActiveReset = 5'd16;

  // Parameter defaults
  localparam int NumBlocksDef = 16;
  localparam int SizeBitsDef  = 16;

  typedef enum logic [0:0] {
    ACT_LOAD  = 1'b0,
    ACT_ALLOC = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

### sv/wfba_size_mem.sv
// Block size table: one write port, one read port with registered data.
// Depends on nothing but its parameters.
module wfba_size_mem #(
  parameter int Depth = 16,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/wfba_core.sv
// Allocator sequencer: used marks, active count, scan over the size table.
// Depends on wfba_pkg, wfba_size_mem and assert_macros.svh.
`include "assert_macros.svh"
module wfba_core
  import wfba_pkg::*;
#(
  parameter int NumBlocks = NumBlocksDef,
  parameter int SizeBits  = SizeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ActW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [BlkW-1:0]     target_block_i,
  input  logic [SizeBits-1:0] size_value_i,
  output logic                res_valid_o,
  input  logic                res_take_i,
  output logic                res_granted_o,
  output logic [BlkW-1:0]     res_block_o,
  output logic [SizeBits-1:0] res_leftover_o,
  output logic [SizeBits-1:0] res_size_o
);

  localparam int IdxW = $clog2(NumBlocks);
  localparam int CntW = $clog2(NumBlocks + 1);

  state_e               state_q, state_d;
  logic [ActW-1:0]      active_q;
  logic [NumBlocks-1:0] used_q, used_d;
  logic [CntW-1:0]      limit_q, limit_d;
  logic [CntW-1:0]      issue_q, issue_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]      cmp_idx_q, cmp_idx_d;
  logic [SizeBits-1:0]  req_q, req_d;
  logic                 found_q, found_d;
  logic [IdxW-1:0]      best_idx_q, best_idx_d;
  logic [SizeBits-1:0]  best_left_q, best_left_d;
  logic [SizeBits-1:0]  best_size_q, best_size_d;

  logic                 mem_we, mem_re;
  logic [IdxW-1:0]      rd_addr, tgt_idx;
  logic [SizeBits-1:0]  rdata, left;
  logic                 tgt_ok, fits;
  logic [CntW-1:0]      lim_calc;

  wfba_size_mem #(
    .Depth (NumBlocks),
    .Width (SizeBits)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tgt_idx),
    .wdata_i (size_value_i),
    .re_i    (mem_re),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign tgt_idx  = IdxW'(target_block_i);
  assign tgt_ok   = 32'(target_block_i) < NumBlocks;
  assign lim_calc = (32'(active_q) > NumBlocks) ? CntW'(NumBlocks) : CntW'(active_q);
  assign rd_addr  = issue_q[IdxW-1:0];

  // compare of the word read last cycle
  assign fits = !used_q[cmp_idx_q] && (rdata >= req_q);
  assign left = rdata - req_q;

  // next state and outputs
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    limit_d     = limit_q;
    issue_d     = issue_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    req_d       = req_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_left_d = best_left_q;
    best_size_d = best_size_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_LOAD) begin
            if (tgt_ok) begin
              mem_we          = 1'b1;
              used_d[tgt_idx] = 1'b0;
            end
          end else begin
            req_d       = size_value_i;
            limit_d     = lim_calc;
            issue_d     = '0;
            found_d     = 1'b0;
            best_idx_d  = '0;
            best_left_d = '0;
            best_size_d = '0;
            state_d     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cmp_vld_q && fits && (!found_q || left > best_left_q)) begin
          found_d     = 1'b1;
          best_idx_d  = cmp_idx_q;
          best_left_d = left;
          best_size_d = rdata;
        end
        if (issue_q < limit_q) begin
          mem_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_addr;
          issue_d   = issue_q + 1'b1;
        end else if (!cmp_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          if (found_q) begin
            used_d[best_idx_q] = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      active_q  <= ActiveReset;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    limit_q     <= limit_d;
    issue_q     <= issue_d;
    cmp_idx_q   <= cmp_idx_d;
    req_q       <= req_d;
    best_idx_q  <= best_idx_d;
    best_left_q <= best_left_d;
    best_size_q <= best_size_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign res_granted_o  = found_q;
  assign res_block_o    = BlkW'(best_idx_q);
  assign res_leftover_o = best_left_q;
  assign res_size_o     = best_size_q;

  `ASSERT_RST(a_idle_no_cmp, clk_i, rst_ni, (state_q == ST_IDLE) |-> !cmp_vld_q)
  `ASSERT_RST(a_issue_bound, clk_i, rst_ni, (state_q == ST_SCAN) |-> (issue_q <= limit_q))
  `ASSERT_RST(a_best_active, clk_i, rst_ni, found_q |-> (CntW'(best_idx_q) < limit_q))
  `ASSERT_RST(a_mark_used, clk_i, rst_ni,
    (state_q == ST_DONE && res_take_i && found_q) |=> used_q[$past(best_idx_q)])

endmodule

### sv/worst_fit_block_allocator_unit.sv
// Worst-fit block allocator top level: core plus result output register; uses wfba_pkg, wfba_core.
// Load word: no result. Allocate word: scans the first limit entries of the size table,
// limit = min(active_blocks, NUM_BLOCKS), one entry per cycle from the read port, then
// the result goes to the result register; the input stalls until the result moves out,
// so an allocate word completes before the next word is taken.
// Reset clears all used marks, sets active_blocks to 16; sizes undefined until loaded.
module worst_fit_block_allocator_unit
  import wfba_pkg::*;
#(
  parameter int NUM_BLOCKS = NumBlocksDef,
  parameter int SIZE_BITS  = SizeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ActW-1:0]      cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 action_i,
  input  logic [BlkW-1:0]      target_block_i,
  input  logic [SIZE_BITS-1:0] size_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 granted_o,
  output logic [BlkW-1:0]      chosen_block_o,
  output logic [SIZE_BITS-1:0] leftover_o,
  output logic [SIZE_BITS-1:0] chosen_size_o
);

  logic                 res_valid, res_take, res_granted;
  logic [BlkW-1:0]      res_block;
  logic [SIZE_BITS-1:0] res_leftover, res_size;
  logic                 out_valid_q;
  logic                 granted_q;
  logic [BlkW-1:0]      block_q;
  logic [SIZE_BITS-1:0] leftover_q, size_q;

  wfba_core #(
    .NumBlocks (NUM_BLOCKS),
    .SizeBits  (SIZE_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .target_block_i (target_block_i),
    .size_value_i   (size_value_i),
    .res_valid_o    (res_valid),
    .res_take_i     (res_take),
    .res_granted_o  (res_granted),
    .res_block_o    (res_block),
    .res_leftover_o (res_leftover),
    .res_size_o     (res_size)
  );

  // output slot is free when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      granted_q  <= res_granted;
      block_q    <= res_block;
      leftover_q <= res_leftover;
      size_q     <= res_size;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_o      = granted_q;
  assign chosen_block_o = block_q;
  assign leftover_o     = leftover_q;
  assign chosen_size_o  = size_q;

endmodule
